/* rtl/sdta_pkg.sv */
// shared types and constants for the signed integer to decimal text converter
// used by sdta_bcd_cell and signed_int_to_decimal_ascii; no dependencies
package sdta_pkg;

    // default width of the integer input
    localparam int VALUE_BITS_DEF = 32;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // largest valid bcd digit
    localparam logic [3:0] BCD_MAX = 4'd9;

    // decimal digits needed for a magnitude of up to 2^(bits-1)
    // 1233/4096 approximates log10(2) closely enough over the whole range
    function automatic int dec_digits(input int bits);
        int r;
        r = (((bits - 1) * 1233) >>> 12) + 1;
        return r;
    endfunction

    // control of one digit cell, common to every cell of the chain
    typedef struct packed {
        logic clear;   // zero the digit
        logic dabble;  // add-3 correction then shift one binary bit in
        logic dshift;  // take the digit of the lower neighbor
    } t_cell_ctl;

endpackage

/* rtl/sdta_bcd_cell.sv */
// one bcd digit cell of the double-dabble chain
// depends on sdta_pkg for the cell control struct
module sdta_bcd_cell
    import sdta_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_bit,    // binary bit from the lower neighbor
    input  logic [3:0] i_digit, // digit of the lower neighbor
    output logic      o_carry,  // bit handed to the upper neighbor
    output logic [3:0] o_digit
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // add 3 when the digit would overflow past 9 after doubling
    assign w_adj   = (r_digit > 4'd4) ? (r_digit + 4'd3) : r_digit;
    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

    // next digit
    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctl.dabble) begin
            n_digit = {w_adj[2:0], i_bit};
        end else if (i_ctl.dshift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// signed integer to decimal ascii text, top level with control and output register
// depends on sdta_pkg and sdta_bcd_cell
// the item is taken, VALUE_BITS double-dabble shifts run through the digit cell
// chain, a minus sign is emitted for a negative value, then each chain digit is
// skipped as a leading zero or emitted as a character, waiting while the output stalls
// a new integer is accepted only in idle, after the last character is loaded for output
// reset (synchronous, active low) returns the controller to idle and empties the output
module signed_int_to_decimal_ascii
    import sdta_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [((VALUE_BITS + 7) / 8)*8-1:0] i_s_tdata,  // [VALUE_BITS-1:0] value
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [7:0]                          o_m_tdata,  // [7:0] character
    output logic                                o_m_tlast   // last
);

    localparam int NDIG   = dec_digits(VALUE_BITS);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int LEFT_W = $clog2(NDIG + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CONV  = 4'b0010,
        S_SIGN  = 4'b0100,
        S_DIGIT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                r_neg, n_neg;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic                r_seen, n_seen;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_char, n_char;
    logic                r_last, n_last;

    logic [VALUE_BITS-1:0] w_raw;
    logic                w_in_acc;
    logic                w_out_free;
    t_cell_ctl           w_ctl;
    logic [3:0]          w_digit [NDIG];
    logic                w_carry [NDIG];
    logic [3:0]          w_top;

    assign w_raw      = i_s_tdata[VALUE_BITS-1:0];
    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_top      = w_digit[NDIG-1];

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_char;
    assign o_m_tlast  = r_last;

    // chain of bcd cells; binary bits enter at the bottom, digits leave at the top
    for (genvar g = 0; g < NDIG; g++) begin : g_cell
        logic       w_bit_in;
        logic [3:0] w_dig_in;
        if (g == 0) begin : g_low
            assign w_bit_in = r_mag[VALUE_BITS-1];
            assign w_dig_in = 4'd0;
        end else begin : g_up
            assign w_bit_in = w_carry[g-1];
            assign w_dig_in = w_digit[g-1];
        end
        sdta_bcd_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_bit   (w_bit_in),
            .i_digit (w_dig_in),
            .o_carry (w_carry[g]),
            .o_digit (w_digit[g])
        );
    end

    // controller
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_seen      = r_seen;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        w_ctl       = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_neg   = w_raw[VALUE_BITS-1];
                    n_mag   = w_raw[VALUE_BITS-1] ? -w_raw : w_raw;
                    n_cnt   = CNT_W'(VALUE_BITS);
                    n_seen  = 1'b0;
                    w_ctl.clear = 1'b1;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                w_ctl.dabble = 1'b1;
                n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_left  = LEFT_W'(NDIG);
                    n_state = r_neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (!r_seen && w_top == 4'd0 && r_left != LEFT_W'(1)) begin
                    // leading zero, drop it
                    w_ctl.dshift = 1'b1;
                    n_left = r_left - 1'b1;
                end else if (w_out_free) begin
                    w_ctl.dshift = 1'b1;
                    n_out_valid  = 1'b1;
                    n_char       = CHAR_ZERO + {4'd0, w_top};
                    n_last       = (r_left == LEFT_W'(1));
                    n_seen       = 1'b1;
                    n_left       = r_left - 1'b1;
                    if (r_left == LEFT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_left      <= '0;
            r_seen      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_seen      <= n_seen;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    // digit emission never runs past the bottom of the chain
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |-> (r_left != '0))
        else $error("digit phase with no digits left");

    // the shift count is live for the whole conversion
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> (r_cnt != '0))
        else $error("conversion with zero shift count");

    // the chain holds valid bcd when digits are read out
    a_bcd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |-> (w_top <= BCD_MAX))
        else $error("top cell holds a non-bcd digit");

    // the final character of a number is always a digit
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> (r_char >= CHAR_ZERO && r_char <= CHAR_ZERO + 8'd9))
        else $error("last character is not a digit");

    // returning to idle from the digit phase always sets the last flag
    a_start_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT && $past(r_state) == S_DIGIT && n_state == S_IDLE)
            |-> n_last)
        else $error("number ended without a last flag");

endmodule
